// ===== sv/eag_pkg.sv =====
// ----------------------------------------------------------------------------
// eag_pkg
// Shared types and codes for the effective address generator.
// ----------------------------------------------------------------------------
`default_nettype none

package eag_pkg;

   localparam logic [1:0] OP_READ  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_RMW   = 2'd2;
   localparam logic [1:0] OP_NONE  = 2'd3;

   localparam logic [3:0] MODE_IMM   = 4'd0;
   localparam logic [3:0] MODE_ABS   = 4'd1;
   localparam logic [3:0] MODE_ZP    = 4'd2;
   localparam logic [3:0] MODE_ZP_X  = 4'd3;
   localparam logic [3:0] MODE_ZP_Y  = 4'd4;
   localparam logic [3:0] MODE_ABS_X = 4'd5;
   localparam logic [3:0] MODE_ABS_Y = 4'd6;
   localparam logic [3:0] MODE_IND_X = 4'd7;
   localparam logic [3:0] MODE_IND_Y = 4'd8;

   localparam logic [1:0] BYTES_ONE = 2'd1;
   localparam logic [1:0] BYTES_TWO = 2'd2;

   typedef struct packed {
      logic [1:0] op;
      logic [3:0] mode;
      logic [7:0] operand_low;
      logic [7:0] operand_high;
      logic [7:0] index_x;
      logic [7:0] index_y;
      logic [7:0] pointer_low;
      logic [7:0] pointer_high;
   } req_type;

   typedef struct packed {
      logic [15:0] effective_address;
      logic        is_immediate;
      logic [7:0]  pointer_address;
      logic        uses_pointer;
      logic        page_crossed;
      logic        first_dummy_valid;
      logic [15:0] first_dummy_address;
      logic        second_dummy_valid;
      logic [15:0] second_dummy_address;
      logic [1:0]  operand_bytes;
      logic        unsupported;
   } rsp_type;

endpackage

`default_nettype wire

// ===== sv/eag_calc.sv =====
// ----------------------------------------------------------------------------
// eag_calc
// Address decode for one registered request: indexing, pointer, dummy reads.
// ----------------------------------------------------------------------------
`default_nettype none

module eag_calc (
   input  wire eag_pkg::req_type req,
   output eag_pkg::rsp_type rsp
);

   logic [7:0]  idx;
   logic [8:0]  zp_sum;
   logic [8:0]  abs_lo_sum;
   logic [8:0]  ind_lo_sum;
   logic [15:0] abs_ea;
   logic [15:0] abs_unc;
   logic [15:0] ind_ea;
   logic [15:0] ind_unc;
   logic        abs_cross;
   logic        ind_cross;
   logic        bad;

   always_comb begin
      idx = (req.mode == eag_pkg::MODE_ABS_X || req.mode == eag_pkg::MODE_ZP_X ||
             req.mode == eag_pkg::MODE_IND_X) ? req.index_x : req.index_y;
      zp_sum     = {1'b0, req.operand_low} + {1'b0, idx};
      abs_lo_sum = {1'b0, req.operand_low} + {1'b0, idx};
      ind_lo_sum = {1'b0, req.pointer_low} + {1'b0, req.index_y};
      abs_cross  = abs_lo_sum[8];
      ind_cross  = ind_lo_sum[8];
      abs_ea     = {req.operand_high + {7'd0, abs_cross}, abs_lo_sum[7:0]};
      abs_unc    = {req.operand_high, abs_lo_sum[7:0]};
      ind_ea     = {req.pointer_high + {7'd0, ind_cross}, ind_lo_sum[7:0]};
      ind_unc    = {req.pointer_high, ind_lo_sum[7:0]};
      bad = (req.op == eag_pkg::OP_NONE) || (req.mode > eag_pkg::MODE_IND_Y) ||
            ((req.op == eag_pkg::OP_RMW) &&
             (req.mode inside {eag_pkg::MODE_IMM, eag_pkg::MODE_ZP_Y}));

      rsp = '0;
      rsp.operand_bytes = eag_pkg::BYTES_ONE;

      if (bad) begin
         rsp.unsupported = 1'b1;
      end else begin
         case (req.mode)
            eag_pkg::MODE_IMM: begin
               rsp.effective_address = {8'd0, req.operand_low};
               rsp.is_immediate      = 1'b1;
            end
            eag_pkg::MODE_ABS: begin
               rsp.effective_address = {req.operand_high, req.operand_low};
               rsp.operand_bytes     = eag_pkg::BYTES_TWO;
            end
            eag_pkg::MODE_ZP: begin
               rsp.effective_address = {8'd0, req.operand_low};
            end
            eag_pkg::MODE_ZP_X, eag_pkg::MODE_ZP_Y: begin
               rsp.effective_address   = {8'd0, zp_sum[7:0]};
               rsp.first_dummy_valid   = 1'b1;
               rsp.first_dummy_address = {8'd0, req.operand_low};
            end
            eag_pkg::MODE_ABS_X, eag_pkg::MODE_ABS_Y: begin
               rsp.effective_address = abs_ea;
               rsp.page_crossed      = abs_cross;
               rsp.operand_bytes     = eag_pkg::BYTES_TWO;
               case (req.op)
                  eag_pkg::OP_READ: begin
                     rsp.second_dummy_valid   = abs_cross;
                     rsp.second_dummy_address = abs_cross ? abs_unc : 16'd0;
                  end
                  eag_pkg::OP_WRITE: begin
                     rsp.second_dummy_valid   = 1'b1;
                     rsp.second_dummy_address = abs_ea;
                  end
                  default: begin
                     rsp.second_dummy_valid   = 1'b1;
                     rsp.second_dummy_address = abs_unc;
                  end
               endcase
            end
            eag_pkg::MODE_IND_X: begin
               rsp.effective_address   = {req.pointer_high, req.pointer_low};
               rsp.pointer_address     = zp_sum[7:0];
               rsp.uses_pointer        = 1'b1;
               rsp.first_dummy_valid   = 1'b1;
               rsp.first_dummy_address = {8'd0, req.operand_low};
            end
            default: begin
               rsp.effective_address = ind_ea;
               rsp.pointer_address   = req.operand_low;
               rsp.uses_pointer      = 1'b1;
               rsp.page_crossed      = ind_cross;
               if (req.op == eag_pkg::OP_READ) begin
                  rsp.first_dummy_valid    = 1'b1;
                  rsp.first_dummy_address  = {8'd0, req.operand_low};
                  rsp.second_dummy_valid   = ind_cross;
                  rsp.second_dummy_address = ind_cross ? ind_unc : 16'd0;
               end else begin
                  rsp.second_dummy_valid   = 1'b1;
                  rsp.second_dummy_address = ind_ea;
               end
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// ===== sv/effective_address_generator_unit.sv =====
// ----------------------------------------------------------------------------
// effective_address_generator_unit
// Operand address generation for a 6502-style core, one request per cycle.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive the req_ fields and raise start; the request is
//   taken at a rising edge where start is high and busy is low. busy is high
//   only while reset is asserted, so a new request may follow every cycle.
//   Result channel: rsp_valid pulses for exactly one cycle with the decoded
//   address, pointer address, page-cross flag, dummy-read addresses, operand
//   byte count and unsupported flag.
// Pipeline: an accepted request is held in the request register, then its
//   decoded result is held in the result register.
// Throughput: one request per cycle; the decode is a single pass of 8-bit
//   adders and selection between the two registers.
// Reset: synchronous, clears both valid bits; no request is in flight after.
// The receiver cannot stall: every result is taken in its single cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module effective_address_generator_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_op,
   input  wire logic [3:0]  req_mode,
   input  wire logic [7:0]  req_operand_low,
   input  wire logic [7:0]  req_operand_high,
   input  wire logic [7:0]  req_index_x,
   input  wire logic [7:0]  req_index_y,
   input  wire logic [7:0]  req_pointer_low,
   input  wire logic [7:0]  req_pointer_high,
   output logic             rsp_valid,
   output logic [15:0]      rsp_effective_address,
   output logic             rsp_is_immediate,
   output logic [7:0]       rsp_pointer_address,
   output logic             rsp_uses_pointer,
   output logic             rsp_page_crossed,
   output logic             rsp_first_dummy_valid,
   output logic [15:0]      rsp_first_dummy_address,
   output logic             rsp_second_dummy_valid,
   output logic [15:0]      rsp_second_dummy_address,
   output logic [1:0]       rsp_operand_bytes,
   output logic             rsp_unsupported
);

   eag_pkg::req_type req_in;
   eag_pkg::req_type req_ff;
   logic             req_valid_in;
   logic             req_valid_ff;
   eag_pkg::rsp_type rsp_in;
   eag_pkg::rsp_type rsp_ff;
   logic             rsp_valid_in;
   logic             rsp_valid_ff;

   assign busy         = reset;
   assign req_valid_in = start & ~busy;
   assign rsp_valid_in = req_valid_ff;

   always_comb begin
      req_in.op           = req_op;
      req_in.mode         = req_mode;
      req_in.operand_low  = req_operand_low;
      req_in.operand_high = req_operand_high;
      req_in.index_x      = req_index_x;
      req_in.index_y      = req_index_y;
      req_in.pointer_low  = req_pointer_low;
      req_in.pointer_high = req_pointer_high;
   end

   eag_calc u_calc (
      .req (req_ff),
      .rsp (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid_in) begin
         req_ff <= req_in;
      end
      if (rsp_valid_in) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid                = rsp_valid_ff;
   assign rsp_effective_address    = rsp_ff.effective_address;
   assign rsp_is_immediate         = rsp_ff.is_immediate;
   assign rsp_pointer_address      = rsp_ff.pointer_address;
   assign rsp_uses_pointer         = rsp_ff.uses_pointer;
   assign rsp_page_crossed         = rsp_ff.page_crossed;
   assign rsp_first_dummy_valid    = rsp_ff.first_dummy_valid;
   assign rsp_first_dummy_address  = rsp_ff.first_dummy_address;
   assign rsp_second_dummy_valid   = rsp_ff.second_dummy_valid;
   assign rsp_second_dummy_address = rsp_ff.second_dummy_address;
   assign rsp_operand_bytes        = rsp_ff.operand_bytes;
   assign rsp_unsupported          = rsp_ff.unsupported;

endmodule

`default_nettype wire
